@@ design/edf_rr_pkg.sv @@
// Package for the EDF scheduler with round robin fallback.
// Holds field widths, task and action codes, and the controller/datapath structs.
// No dependencies.
package edf_rr_pkg;

    // Fixed field widths of the item channels and the slice counter.
    localparam int SLOT_PORT_W     = 4;
    localparam int STATUS_W        = 2;
    localparam int DEADLINE_PORT_W = 32;
    localparam int QUANTUM_W       = 16;
    localparam int COUNTER_W       = 17;

    // Task status codes.
    localparam logic [STATUS_W-1:0] TASK_BLOCKED = 2'd0;
    localparam logic [STATUS_W-1:0] TASK_RUNNING = 2'd3;

    // Input item actions.
    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    // Most negative slice counter value; decrements saturate here.
    localparam logic [COUNTER_W-1:0] COUNTER_MIN = 17'h10000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic slot_write;
        logic scan_init_edf;
        logic scan_init_rr;
        logic scan_run;
        logic edf_acc;
        logic rr_seek;
        logic cur_read;
        logic charge;
        logic rr_finish;
        logic edf_pick;
        logic no_pick;
        logic res_load;
    } edf_rr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic policy_mode;
        logic scan_drained;
        logic edf_have;
        logic edf_no_deadline;
        logic keep_running;
        logic rr_hit;
        logic out_busy;
    } edf_rr_stat_t;

endpackage

@@ design/edf_rr_in_if.sv @@
// Input item channel of the EDF scheduler: valid/ready plus the task slot payload.
// Depends on edf_rr_pkg for the field widths.
interface edf_rr_in_if;
    import edf_rr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [SLOT_PORT_W-1:0]     slot_index;
    logic [STATUS_W-1:0]        task_status;
    logic [DEADLINE_PORT_W-1:0] task_deadline;
    logic [QUANTUM_W-1:0]       task_quantum;

    modport source (
        output valid, action, slot_index, task_status, task_deadline, task_quantum,
        input  ready
    );

    modport sink (
        input  valid, action, slot_index, task_status, task_deadline, task_quantum,
        output ready
    );
endinterface

@@ design/edf_rr_out_if.sv @@
// Result item channel of the EDF scheduler: valid/ready plus the selection payload.
// Depends on edf_rr_pkg for the field widths.
interface edf_rr_out_if;
    import edf_rr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   switch_valid;
    logic [SLOT_PORT_W-1:0] chosen_slot;
    logic                   nothing_ready;

    modport source (
        output valid, switch_valid, chosen_slot, nothing_ready,
        input  ready
    );

    modport sink (
        input  valid, switch_valid, chosen_slot, nothing_ready,
        output ready
    );
endinterface

@@ design/edf_rr_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module edf_rr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

@@ design/edf_rr_ctrl.sv @@
// Sequencing state machine of the EDF scheduler.
// Depends on edf_rr_pkg; drives edf_rr_dp through command and status structs.
module edf_rr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_action,
    output logic                    in_ready,
    output edf_rr_pkg::edf_rr_cmd_t cmd,
    input  edf_rr_pkg::edf_rr_stat_t stat
);
    import edf_rr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EDF_SCAN = 7'b0000010,
        ST_RR_CUR   = 7'b0000100,
        ST_RR_CHG   = 7'b0001000,
        ST_RR_SCAN  = 7'b0010000,
        ST_RR_END   = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ACTION_WRITE)
                    begin
                        cmd.slot_write = 1'b1;
                    end
                    else if (stat.policy_mode)
                    begin
                        cmd.scan_init_edf = 1'b1;
                        state_next        = ST_EDF_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RR_CUR;
                    end
                end
            end
            ST_EDF_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.edf_acc  = 1'b1;
                if (stat.scan_drained)
                begin
                    if (!stat.edf_have)
                    begin
                        cmd.no_pick = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    else if (stat.edf_no_deadline)
                    begin
                        state_next = ST_RR_CUR;
                    end
                    else
                    begin
                        cmd.edf_pick = 1'b1;
                        state_next   = ST_RESULT;
                    end
                end
            end
            ST_RR_CUR:
            begin
                cmd.cur_read = 1'b1;
                state_next   = ST_RR_CHG;
            end
            ST_RR_CHG:
            begin
                cmd.charge = 1'b1;
                if (stat.keep_running)
                begin
                    cmd.no_pick = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    cmd.scan_init_rr = 1'b1;
                    state_next       = ST_RR_SCAN;
                end
            end
            ST_RR_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.rr_seek  = 1'b1;
                if (stat.rr_hit || stat.scan_drained)
                begin
                    state_next = ST_RR_END;
                end
            end
            ST_RR_END:
            begin
                cmd.rr_finish = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ design/edf_rr_dp.sv @@
// Datapath of the EDF scheduler: slot table RAM, scan engine, selection and result register.
// Depends on edf_rr_pkg and edf_rr_ram; commanded by edf_rr_ctrl.
module edf_rr_dp #(
    parameter int TASK_SLOTS    = 16,
    parameter int DEADLINE_BITS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic                                       cfg_wr_data,
    input  logic [edf_rr_pkg::SLOT_PORT_W-1:0]         slot_index,
    input  logic [edf_rr_pkg::STATUS_W-1:0]            task_status,
    input  logic [edf_rr_pkg::DEADLINE_PORT_W-1:0]     task_deadline,
    input  logic [edf_rr_pkg::QUANTUM_W-1:0]           task_quantum,
    input  edf_rr_pkg::edf_rr_cmd_t                    cmd,
    output edf_rr_pkg::edf_rr_stat_t                   stat,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic                                       switch_valid,
    output logic [edf_rr_pkg::SLOT_PORT_W-1:0]         chosen_slot,
    output logic                                       nothing_ready
);
    import edf_rr_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int SCAN_W = $clog2(TASK_SLOTS + 1);
    localparam int Q_LSB  = COUNTER_W;
    localparam int DL_LSB = Q_LSB + QUANTUM_W;
    localparam int ST_LSB = DL_LSB + DEADLINE_BITS;
    localparam int WORD_W = ST_LSB + STATUS_W;
    localparam logic [DEADLINE_BITS-1:0] NO_DEADLINE = '1;
    localparam logic [SCAN_W-1:0]        SLOT_COUNT  = SCAN_W'(TASK_SLOTS);

    // Configuration and table bookkeeping.
    logic                     policy_reg;
    logic [TASK_SLOTS-1:0]    slot_ok_reg;
    logic                     rd_ok_reg;

    // Scan engine.
    logic [SCAN_W-1:0]        scan_addr_reg;
    logic [SLOT_W-1:0]        tag_reg;
    logic                     tag_live_reg;
    logic                     scan_issue;
    logic [SCAN_W-1:0]        rr_start;

    // EDF best candidate and round robin find.
    logic                     have_reg;
    logic [SLOT_W-1:0]        best_slot_reg;
    logic [DEADLINE_BITS-1:0] best_dl_reg;
    logic                     found_reg;
    logic [SLOT_W-1:0]        found_slot_reg;

    // Current task and its latched table word.
    logic [SLOT_W-1:0]        cur_slot_reg;
    logic                     cur_valid_reg;
    logic [STATUS_W-1:0]      cw_status_reg;
    logic [DEADLINE_BITS-1:0] cw_dl_reg;
    logic [QUANTUM_W-1:0]     cw_q_reg;
    logic [COUNTER_W-1:0]     cw_cnt_reg;

    // Pending and presented result.
    logic                     pend_sw_reg;
    logic [SLOT_W-1:0]        pend_slot_reg;
    logic                     pend_nr_reg;
    logic                     out_valid_reg;
    logic                     out_sw_reg;
    logic [SLOT_PORT_W-1:0]   out_slot_reg;
    logic                     out_nr_reg;

    // RAM ports.
    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    logic [WORD_W-1:0]        ram_wdata;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [WORD_W-1:0]        ram_rdata;

    // Read word with unwritten entries shown as their reset value.
    logic [STATUS_W-1:0]      eff_status;
    logic [DEADLINE_BITS-1:0] eff_dl;
    logic [QUANTUM_W-1:0]     eff_q;
    logic [COUNTER_W-1:0]     eff_cnt;

    logic [31:0]              idx_wide;
    logic                     in_range;
    logic [63:0]              dl_wide;
    logic                     charge_en;
    logic [COUNTER_W-1:0]     charged_cnt;
    logic                     edf_hit;
    logic                     rr_hit;
    logic [SLOT_W-1:0]        rr_pick;
    logic                     rr_none;
    logic                     reload_en;
    logic [31:0]              pend_slot_wide;

    edf_rr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Field decode of the read word.
    assign eff_status = rd_ok_reg ? ram_rdata[ST_LSB +: STATUS_W] : TASK_BLOCKED;
    assign eff_dl     = rd_ok_reg ? ram_rdata[DL_LSB +: DEADLINE_BITS] : NO_DEADLINE;
    assign eff_q      = rd_ok_reg ? ram_rdata[Q_LSB +: QUANTUM_W] : '0;
    assign eff_cnt    = rd_ok_reg ? ram_rdata[0 +: COUNTER_W] : '0;

    // Write item addressing and deadline sizing.
    assign idx_wide = 32'(slot_index);
    assign in_range = idx_wide < 32'(TASK_SLOTS);
    assign dl_wide  = 64'(task_deadline);

    // Charge one slice to a running current task, saturating at the bottom.
    assign charge_en   = cur_valid_reg && (eff_status == TASK_RUNNING);
    assign charged_cnt = (charge_en && (eff_cnt != COUNTER_MIN)) ?
                         eff_cnt - COUNTER_W'(1) : eff_cnt;

    // Round robin outcome after the scan.
    assign rr_pick   = found_reg ? found_slot_reg : cur_slot_reg;
    assign rr_none   = !found_reg && !cur_valid_reg;
    assign reload_en = cur_valid_reg && (rr_pick == cur_slot_reg) &&
                       (cw_cnt_reg[COUNTER_W-1] || (cw_cnt_reg == '0));

    // Scan hits.
    assign edf_hit = cmd.edf_acc && tag_live_reg && (eff_status != TASK_BLOCKED);
    assign rr_hit  = cmd.rr_seek && tag_live_reg && (eff_status != TASK_BLOCKED);

    // Round robin start: slot after the current one, else slot zero.
    always_comb
    begin
        rr_start = SCAN_W'(cur_slot_reg) + SCAN_W'(1);
        if (!cur_valid_reg || (rr_start >= SLOT_COUNT))
        begin
            rr_start = '0;
        end
    end

    assign scan_issue = cmd.scan_run && (scan_addr_reg < SLOT_COUNT);
    assign ram_raddr  = cmd.cur_read ? cur_slot_reg : scan_addr_reg[SLOT_W-1:0];

    // Table write select: slot load, slice charge or quantum reload.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_slot_reg;
        ram_wdata = {eff_status, eff_dl, eff_q, charged_cnt};
        if (cmd.slot_write && in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_wide[SLOT_W-1:0];
            ram_wdata = {task_status, dl_wide[DEADLINE_BITS-1:0], task_quantum,
                         COUNTER_W'(0)};
        end
        else if (cmd.charge && charge_en)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.rr_finish && reload_en)
        begin
            ram_we    = 1'b1;
            ram_wdata = {cw_status_reg, cw_dl_reg, cw_q_reg, COUNTER_W'(cw_q_reg)};
        end
    end

    // Policy register and per-slot written flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= 1'b1;
            slot_ok_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                policy_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                slot_ok_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Read tag pipeline that follows the registered RAM read.
    always_ff @(posedge clk)
    begin
        tag_reg   <= scan_addr_reg[SLOT_W-1:0];
        rd_ok_reg <= slot_ok_reg[ram_raddr];
    end

    // Scan address, EDF best and round robin find.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            tag_live_reg   <= 1'b0;
            have_reg       <= 1'b0;
            best_slot_reg  <= '0;
            best_dl_reg    <= '0;
            found_reg      <= 1'b0;
            found_slot_reg <= '0;
        end
        else
        begin
            if (cmd.scan_init_edf)
            begin
                scan_addr_reg <= '0;
                tag_live_reg  <= 1'b0;
                have_reg      <= 1'b0;
            end
            else if (cmd.scan_init_rr)
            begin
                scan_addr_reg <= rr_start;
                tag_live_reg  <= 1'b0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_addr_reg <= scan_addr_reg + SCAN_W'(1);
                end
                tag_live_reg <= scan_issue;
            end
            // Earliest deadline wins; a slot with no deadline never displaces the best.
            if (edf_hit)
            begin
                if (!have_reg || ((eff_dl != NO_DEADLINE) && (best_dl_reg > eff_dl)))
                begin
                    best_slot_reg <= tag_reg;
                    best_dl_reg   <= eff_dl;
                end
                have_reg <= 1'b1;
            end
            if (rr_hit)
            begin
                found_reg      <= 1'b1;
                found_slot_reg <= tag_reg;
            end
        end
    end

    // Latch the current slot's word when it is charged.
    always_ff @(posedge clk)
    begin
        if (cmd.charge)
        begin
            cw_status_reg <= eff_status;
            cw_dl_reg     <= eff_dl;
            cw_q_reg      <= eff_q;
            cw_cnt_reg    <= charged_cnt;
        end
    end

    // Current task update on a selection.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
        end
        else if (cmd.edf_pick)
        begin
            cur_slot_reg  <= best_slot_reg;
            cur_valid_reg <= 1'b1;
        end
        else if (cmd.rr_finish && !rr_none)
        begin
            cur_slot_reg  <= rr_pick;
            cur_valid_reg <= 1'b1;
        end
    end

    // Pending result of the tick in flight.
    always_ff @(posedge clk)
    begin
        if (cmd.edf_pick)
        begin
            pend_sw_reg   <= 1'b1;
            pend_slot_reg <= best_slot_reg;
            pend_nr_reg   <= 1'b0;
        end
        else if (cmd.no_pick || (cmd.rr_finish && rr_none))
        begin
            pend_sw_reg   <= 1'b0;
            pend_slot_reg <= '0;
            pend_nr_reg   <= !cur_valid_reg;
        end
        else if (cmd.rr_finish)
        begin
            pend_sw_reg   <= 1'b1;
            pend_slot_reg <= rr_pick;
            pend_nr_reg   <= 1'b0;
        end
    end

    assign pend_slot_wide = 32'(pend_slot_reg);

    // Output register: holds a result item until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_sw_reg   <= pend_sw_reg;
            out_slot_reg <= pend_slot_wide[SLOT_PORT_W-1:0];
            out_nr_reg   <= pend_nr_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign switch_valid  = out_sw_reg;
    assign chosen_slot   = out_slot_reg;
    assign nothing_ready = out_nr_reg;

    // Status back to the controller.
    assign stat.policy_mode     = policy_reg;
    assign stat.scan_drained    = (scan_addr_reg == SLOT_COUNT) && !tag_live_reg;
    assign stat.edf_have        = have_reg;
    assign stat.edf_no_deadline = (best_dl_reg == NO_DEADLINE);
    assign stat.keep_running    = charge_en && !charged_cnt[COUNTER_W-1] &&
                                  (charged_cnt != '0);
    assign stat.rr_hit          = rr_hit;
    assign stat.out_busy        = out_valid_reg && !out_ready;
endmodule

@@ design/edf_scheduler_rr_fallback_top.sv @@
// EDF task scheduler with round robin fallback: usage notes.
//
// Input items arrive on in_ch (valid/ready). An item with action write loads one task
// slot (status, deadline, quantum) and clears its slice counter, and
// gives no result. An item with action tick selects the next task and gives exactly one
// result item on out_ch: switch_valid, chosen_slot and nothing_ready.
// A tick in EDF mode scans the slot table one slot per cycle through the table RAM read
// port, then the result item is loaded. In round robin mode the current slot is read and
// charged; if the running task keeps its slice the result follows directly, else a forward
// scan runs one slot per cycle until a non-blocked slot is found or the table ends. When
// the EDF pick has no deadline the round robin pass follows the EDF scan. The next item
// can be taken in the cycle after the result is loaded.
// A new item is accepted only while no tick is in progress, one item at a time.
// Results sit in an output register; while the receiver stalls, write items are still
// taken, and a finished tick waits for that register before the next item is accepted.
// The user writes policy_mode via cfg_wr_en/cfg_wr_data only while the block is idle;
// the block does not enforce this. After reset: policy_mode is EDF, every slot reads as
// blocked with no deadline, no current task, no result pending. No clearing pass is needed.
module edf_scheduler_rr_fallback_top #(
    parameter int TASK_SLOTS    = 16,
    parameter int DEADLINE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    edf_rr_in_if.sink    in_ch,
    edf_rr_out_if.source out_ch
);
    import edf_rr_pkg::*;

    edf_rr_cmd_t  cmd;
    edf_rr_stat_t stat;
    logic         in_ready;

    assign in_ch.ready = in_ready;

    // Sequencer.
    edf_rr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Slot table, scan engine and result register.
    edf_rr_dp #(
        .TASK_SLOTS    (TASK_SLOTS),
        .DEADLINE_BITS (DEADLINE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .slot_index    (in_ch.slot_index),
        .task_status   (in_ch.task_status),
        .task_deadline (in_ch.task_deadline),
        .task_quantum  (in_ch.task_quantum),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .switch_valid  (out_ch.switch_valid),
        .chosen_slot   (out_ch.chosen_slot),
        .nothing_ready (out_ch.nothing_ready)
    );
endmodule
